// ----- rtl/core/mvsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants of the stereo voice mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

	localparam int VOICES     = 16;
	localparam int VOICE_W    = $clog2(VOICES);
	localparam int STORE_AW   = 14;
	localparam int LEN_W      = 15;
	localparam int GAIN_W     = 16;
	localparam int SMP_W      = 16;
	localparam int PROD_W     = 49;
	localparam int ACC_W      = 54;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd32768;

	typedef enum logic [1:0] {
		K_LOAD  = 2'd0,
		K_PLAY  = 2'd1,
		K_STOP  = 2'd2,
		K_FRAME = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		R_GAIN_L = 1'b0,
		R_GAIN_R = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_ADDR, S_L1, S_L2, S_R1, S_R2,
		S_FIN0, S_FIN1, S_FIN2, S_DONE
	} state_t;

	// Command to the shared multiply-accumulate unit
	typedef struct packed {
		logic clr;
		logic mul;
		logic acc_l;
		logic acc_r;
	} mac_cmd_t;

endpackage

// ----- rtl/core/mvsm_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_req_if / mvsm_rsp_if
// Request and response channels of the mixer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mvsm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [13:0] address;
	logic [14:0] length;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic [15:0] gain_left;
	logic [15:0] gain_right;
	logic        looped;
	logic [3:0]  slot;
	logic        end_of_buffer;

	modport source(output valid, kind, address, length, left_sample, right_sample,
		gain_left, gain_right, looped, slot, end_of_buffer, input ready);
	modport sink(input valid, kind, address, length, left_sample, right_sample,
		gain_left, gain_right, looped, slot, end_of_buffer, output ready);
endinterface

interface mvsm_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] out_left;
	logic signed [15:0] out_right;
	logic [3:0]  granted_slot;
	logic        no_free_slot;

	modport source(output valid, out_left, out_right, granted_slot, no_free_slot,
		input ready);
	modport sink(input valid, out_left, out_right, granted_slot, no_free_slot,
		output ready);
endinterface

// ----- rtl/core/multi_voice_stereo_mixer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_stereo_mixer_unit
// Sixteen-voice stereo mixer over a 16K-word sample store.
// ----------------------------------------------------------------------------
// Load, play and stop requests pass through the execute and done states to the
// response register. A frame request also visits every voice in turn; each
// voice still sounding needs one store read and four passes through the single
// shared multiplier (sample by voice gain, then by master gain, for each
// channel). No request is taken while one is being worked on; a finished
// response may still wait in the output register while the next request is
// accepted.
module multi_voice_stereo_mixer_unit
	import mvsm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mvsm_req_if.sink     req,
	mvsm_rsp_if.source   rsp,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	state_t state_q, state_d;

	// latched request
	logic [1:0]          kind_q;
	logic [STORE_AW-1:0] addr_q;
	logic [LEN_W-1:0]    len_q;
	logic [31:0]         word_q;
	logic [GAIN_W-1:0]   vgl_in_q, vgr_in_q;
	logic                loop_in_q, eob_q;
	logic [3:0]          slot_in_q;

	// voice table
	logic [VOICES-1:0]   active_q, looped_q;
	logic [STORE_AW-1:0] start_q [VOICES];
	logic [LEN_W-1:0]    vlen_q  [VOICES];
	logic [LEN_W-1:0]    pos_q   [VOICES];
	logic [GAIN_W-1:0]   vgl_q   [VOICES];
	logic [GAIN_W-1:0]   vgr_q   [VOICES];

	logic [GAIN_W-1:0]   ggl_q, ggr_q;
	logic [VOICE_W-1:0]  v_q;
	logic                pend_r_q;

	// results
	logic signed [15:0]  res_l_q, res_r_q;
	logic [3:0]          res_slot_q;
	logic                res_full_q;
	logic                out_valid_q;
	logic signed [15:0]  out_l_q, out_r_q;
	logic [3:0]          out_slot_q;
	logic                out_full_q;

	logic signed [ACC_W-1:0] t_l_q, t_r_q;

	// store and MAC
	logic [31:0]         rdata;
	logic                st_we, st_re;
	logic [STORE_AW-1:0] st_raddr;
	mac_cmd_t            cmd;
	logic signed [31:0]  op_a;
	logic signed [16:0]  op_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_l_q, acc_r_q;

	mvsm_store u_store (
		.clk(clk), .we(st_we), .waddr(addr_q), .wdata(word_q),
		.re(st_re), .raddr(st_raddr), .rdata(rdata)
	);

	mvsm_mac u_mac (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .op_a(op_a), .op_b(op_b),
		.prod_q(prod_q), .acc_l_q(acc_l_q), .acc_r_q(acc_r_q)
	);

	// lowest free slot
	logic [VOICE_W-1:0] free_idx;
	logic               any_free;
	always_comb begin
		free_idx = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!active_q[i]) free_idx = VOICE_W'(i);
		end
		any_free = ~&active_q;
	end

	logic elig, last_v;
	assign elig   = active_q[v_q] && (pos_q[v_q] < vlen_q[v_q]);
	assign last_v = (v_q == VOICE_W'(VOICES - 1));
	assign st_raddr = start_q[v_q] + pos_q[v_q][STORE_AW-1:0];

	// truncate toward zero and saturate; the half for rounding is added before the call
	function automatic logic signed [15:0] finish(input logic signed [ACC_W-1:0] t);
		logic signed [ACC_W-1:0] adj;
		logic signed [ACC_W-31:0] q;
		adj = t[ACC_W-1] ? t + ACC_W'((64'd1 << 30) - 64'd1) : t;
		q = adj[ACC_W-1:30];
		if (q > 32767) return 16'sd32767;
		else if (q < -32768) return -16'sd32768;
		else return q[15:0];
	endfunction

	// sequencer: next state and datapath controls
	always_comb begin
		state_d = state_q;
		st_we = 1'b0;
		st_re = 1'b0;
		cmd = '0;
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_IDLE: if (req.valid) state_d = S_EXEC;
			S_EXEC: begin
				st_we = (kind_q == K_LOAD);
				cmd.clr = (kind_q == K_FRAME);
				state_d = (kind_q == K_FRAME) ? S_ADDR : S_DONE;
			end
			S_ADDR: begin
				cmd.acc_r = pend_r_q;
				st_re = elig;
				if (elig) state_d = S_L1;
				else if (last_v) state_d = S_FIN0;
			end
			S_L1: begin
				cmd.mul = 1'b1;
				op_a = 32'(signed'(rdata[15:0]));
				op_b = signed'({1'b0, vgl_q[v_q]});
				state_d = S_L2;
			end
			S_L2: begin
				cmd.mul = 1'b1;
				op_a = prod_q[31:0];
				op_b = signed'({1'b0, ggl_q});
				state_d = S_R1;
			end
			S_R1: begin
				cmd.acc_l = 1'b1;
				cmd.mul = 1'b1;
				op_a = 32'(signed'(rdata[31:16]));
				op_b = signed'({1'b0, vgr_q[v_q]});
				state_d = S_R2;
			end
			S_R2: begin
				cmd.mul = 1'b1;
				op_a = prod_q[31:0];
				op_b = signed'({1'b0, ggr_q});
				state_d = last_v ? S_FIN0 : S_ADDR;
			end
			S_FIN0: begin
				cmd.acc_r = pend_r_q;
				state_d = S_FIN1;
			end
			S_FIN1: state_d = S_FIN2;
			S_FIN2: state_d = S_DONE;
			S_DONE: if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign req.ready = (state_q == S_IDLE);

	// request latch
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q    <= req.kind;
			addr_q    <= req.address;
			len_q     <= req.length;
			word_q    <= {req.right_sample, req.left_sample};
			vgl_in_q  <= req.gain_left;
			vgr_in_q  <= req.gain_right;
			loop_in_q <= req.looped;
			slot_in_q <= req.slot;
			eob_q     <= req.end_of_buffer;
		end
	end

	// master gains, clamped to unity on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ggl_q <= GAIN_ONE;
			ggr_q <= GAIN_ONE;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				R_GAIN_L: ggl_q <= (cfg_data > GAIN_ONE) ? GAIN_ONE : cfg_data;
				R_GAIN_R: ggr_q <= (cfg_data > GAIN_ONE) ? GAIN_ONE : cfg_data;
				default: ;
			endcase
		end
	end

	// voice flags, counter and pending right-channel add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			looped_q <= '0;
			v_q <= '0;
			pend_r_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_EXEC: begin
					v_q <= '0;
					pend_r_q <= 1'b0;
					if (kind_q == K_PLAY && any_free) begin
						active_q[free_idx] <= 1'b1;
						looped_q[free_idx] <= loop_in_q;
					end
					if (kind_q == K_STOP && 32'(slot_in_q) < VOICES)
						active_q[slot_in_q[VOICE_W-1:0]] <= 1'b0;
				end
				S_ADDR: begin
					pend_r_q <= 1'b0;
					if (!elig && !last_v) v_q <= v_q + 1'b1;
				end
				S_R2: begin
					pend_r_q <= 1'b1;
					if (!last_v) v_q <= v_q + 1'b1;
				end
				S_FIN0: pend_r_q <= 1'b0;
				S_FIN2: begin
					if (eob_q) begin
						for (int i = 0; i < VOICES; i++) begin
							if (active_q[i] && pos_q[i] >= vlen_q[i] && !looped_q[i])
								active_q[i] <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// voice payload
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && kind_q == K_PLAY && any_free) begin
			start_q[free_idx] <= addr_q;
			vlen_q[free_idx]  <= len_q;
			pos_q[free_idx]   <= '0;
			vgl_q[free_idx]   <= vgl_in_q;
			vgr_q[free_idx]   <= vgr_in_q;
		end
		if (state_q == S_ADDR && elig) begin
			pos_q[v_q] <= pos_q[v_q] + 1'b1;
		end
		if (state_q == S_FIN2 && eob_q) begin
			for (int i = 0; i < VOICES; i++) begin
				if (active_q[i] && pos_q[i] >= vlen_q[i] && looped_q[i])
					pos_q[i] <= '0;
			end
		end
	end

	// result formation
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			res_l_q <= '0;
			res_r_q <= '0;
			res_slot_q <= (kind_q == K_PLAY && any_free) ? 4'(free_idx) : 4'd0;
			res_full_q <= (kind_q == K_PLAY) && !any_free;
		end
		if (state_q == S_FIN1) begin
			t_l_q <= acc_l_q + ACC_W'(64'd1 << 29);
			t_r_q <= acc_r_q + ACC_W'(64'd1 << 29);
		end
		if (state_q == S_FIN2) begin
			res_l_q <= finish(t_l_q);
			res_r_q <= finish(t_r_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_l_q    <= res_l_q;
			out_r_q    <= res_r_q;
			out_slot_q <= res_slot_q;
			out_full_q <= res_full_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_left     = out_l_q;
	assign rsp.out_right    = out_r_q;
	assign rsp.granted_slot = out_slot_q;
	assign rsp.no_free_slot = out_full_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state_q == S_IDLE)
		else $error("request taken while busy");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside completion");

	a_play_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && kind_q == K_PLAY && any_free) |=> active_q[$past(free_idx)])
		else $error("granted slot not marked active");

endmodule

// ----- rtl/core/mvsm_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_store
// Sample store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mvsm_store
	import mvsm_pkg::*;
(
	input  logic                clk,
	input  logic                we,
	input  logic [STORE_AW-1:0] waddr,
	input  logic [31:0]         wdata,
	input  logic                re,
	input  logic [STORE_AW-1:0] raddr,
	output logic [31:0]         rdata
);

	logic [31:0] mem_q [2**STORE_AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/mvsm_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_mac
// Shared multiplier with registered product and two channel accumulators.
// ----------------------------------------------------------------------------
module mvsm_mac
	import mvsm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_cmd_t                cmd,
	input  logic signed [31:0]      op_a,
	input  logic signed [16:0]      op_b,
	output logic signed [PROD_W-1:0] prod_q,
	output logic signed [ACC_W-1:0]  acc_l_q,
	output logic signed [ACC_W-1:0]  acc_r_q
);

	// product register
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PROD_W'(op_a * op_b);
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (cmd.clr) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else begin
			if (cmd.acc_l) acc_l_q <= acc_l_q + ACC_W'(prod_q);
			if (cmd.acc_r) acc_r_q <= acc_r_q + ACC_W'(prod_q);
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the stereo voice mixer against a predictor of its own. The low part
// of the sample store is filled first, then a table of directed requests
// runs, then random load, play, stop and frame requests run in phases under
// several master gain settings. Random plays only cover loaded words. Both
// channels idle at random, and the response side stalls once for a long
// stretch so that the mixer backs up.
// ----------------------------------------------------------------------------
module testbench;
	import mvsm_pkg::*;

	localparam int FILL_WORDS = 256;

	typedef struct {
		kind_t              kind;
		logic [13:0]        address;
		logic [14:0]        length;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [15:0]        gain_left;
		logic [15:0]        gain_right;
		logic               looped;
		logic [3:0]         slot;
		logic               end_of_buffer;
	} mix_req_t;

	typedef struct {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
		logic [3:0]         granted_slot;
		logic               no_free_slot;
	} mix_rsp_t;

	typedef struct {
		mix_req_t r;
		bit       typed;
		mix_rsp_t e;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	mvsm_req_if req_ch ();
	mvsm_rsp_if rsp_ch ();

	multi_voice_stereo_mixer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predictor state
	logic [31:0] store_mem [16384];
	logic        v_act   [VOICES];
	logic        v_loop  [VOICES];
	logic [13:0] v_start [VOICES];
	logic [14:0] v_len   [VOICES];
	logic [14:0] v_pos   [VOICES];
	logic [15:0] v_gl    [VOICES];
	logic [15:0] v_gr    [VOICES];
	logic [15:0] master_l;
	logic [15:0] master_r;

	mix_rsp_t mix_pending [$];
	int       n_errors;
	int       n_sent;
	int       n_got;
	int       n_frames;
	int       n_nofree;
	int       n_sat;
	bit       calm;
	bit       long_hold_done;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("testbench: FAIL");
		$finish;
	end

	// Round to nearest, truncate toward zero, saturate to 16 bits
	function automatic logic signed [15:0] round_sat(longint s);
		longint t;
		longint q;
		t = s + (longint'(1) << 29);
		if (t >= 0)
			q = t >>> 30;
		else
			q = -((-t) >>> 30);
		if (q > 32767 || q < -32768)
			n_sat++;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	// Predicted response of one request, updating the voice state
	function automatic mix_rsp_t mix_predict(mix_req_t r);
		mix_rsp_t o;
		int found;
		longint sl;
		longint sr;
		logic [31:0] w;
		logic [13:0] a;
		o = '{default: '0};
		found = -1;
		sl = 0;
		sr = 0;
		case (r.kind)
			K_LOAD: store_mem[r.address] = {r.right_sample, r.left_sample};
			K_PLAY: begin
				for (int v = 0; v < VOICES; v++)
					if (!v_act[v] && found < 0)
						found = v;
				if (found < 0) begin
					o.no_free_slot = 1'b1;
					n_nofree++;
				end else begin
					v_act[found]   = 1'b1;
					v_loop[found]  = r.looped;
					v_start[found] = r.address;
					v_len[found]   = r.length;
					v_pos[found]   = '0;
					v_gl[found]    = r.gain_left;
					v_gr[found]    = r.gain_right;
					o.granted_slot = found[3:0];
				end
			end
			K_STOP: v_act[r.slot] = 1'b0;
			default: begin
				n_frames++;
				for (int v = 0; v < VOICES; v++) begin
					if (v_act[v] && v_pos[v] < v_len[v]) begin
						a = v_start[v] + v_pos[v][13:0];
						w = store_mem[a];
						sl += longint'($signed(w[15:0])) * longint'(v_gl[v]) * longint'(master_l);
						sr += longint'($signed(w[31:16])) * longint'(v_gr[v]) * longint'(master_r);
						v_pos[v]++;
					end
				end
				o.out_left  = round_sat(sl);
				o.out_right = round_sat(sr);
				// End of buffer: finished looped voices restart, others free up
				if (r.end_of_buffer)
					for (int v = 0; v < VOICES; v++)
						if (v_act[v] && v_pos[v] >= v_len[v]) begin
							if (v_loop[v])
								v_pos[v] = '0;
							else
								v_act[v] = 1'b0;
						end
			end
		endcase
		return o;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 60)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Send one request; returns once it is accepted
	task automatic send_req(mix_req_t r, bit typed, mix_rsp_t e);
		int gap;
		bit acc;
		mix_rsp_t p;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.kind          <= r.kind;
		req_ch.address       <= r.address;
		req_ch.length        <= r.length;
		req_ch.left_sample   <= r.left_sample;
		req_ch.right_sample  <= r.right_sample;
		req_ch.gain_left     <= r.gain_left;
		req_ch.gain_right    <= r.gain_right;
		req_ch.looped        <= r.looped;
		req_ch.slot          <= r.slot;
		req_ch.end_of_buffer <= r.end_of_buffer;
		acc = 1'b0;
		while (!acc) begin
			@(negedge clk);
			acc = req_ch.ready;
			@(posedge clk);
		end
		p = mix_predict(r);
		mix_pending.push_back(typed ? e : p);
		n_sent++;
	endtask

	function automatic mix_req_t rand_req();
		mix_req_t r;
		int p;
		int room;
		p = $urandom_range(0, 99);
		r.kind          = p < 12 ? K_LOAD : p < 32 ? K_PLAY : p < 45 ? K_STOP : K_FRAME;
		r.address       = 14'($urandom);
		p = $urandom_range(0, 99);
		r.length        = p < 5 ? 15'd0 : p < 92 ? 15'($urandom_range(1, 48))
			: 15'($urandom_range(0, 16384));
		r.left_sample   = 16'($urandom);
		r.right_sample  = 16'($urandom);
		r.gain_left     = 16'($urandom);
		r.gain_right    = 16'($urandom);
		r.looped        = 1'($urandom);
		r.slot          = 4'($urandom);
		r.end_of_buffer = $urandom_range(0, 7) == 0;
		// plays only read words that were loaded
		if (r.kind == K_PLAY) begin
			r.address = 14'($urandom_range(0, FILL_WORDS / 2 - 1));
			room = FILL_WORDS - int'(r.address);
			if (p >= 92)
				r.length = 15'($urandom_range(49, room));
		end
		return r;
	endfunction

	function automatic dir_row_t mk_row(kind_t k, int addr, int len, int ls, int rs,
		int gl, int gr, bit lp, int sl, bit eob, bit typed, int gslot);
		dir_row_t d;
		d.r = '{k, addr[13:0], len[14:0], ls[15:0], rs[15:0], gl[15:0], gr[15:0],
			lp, sl[3:0], eob};
		d.typed = typed;
		d.e = '{16'sd0, 16'sd0, gslot[3:0], 1'b0};
		return d;
	endfunction

	task automatic drain();
		while (mix_pending.size() != 0)
			@(posedge clk);
		// the last response may be followed by a frame still in flight
		repeat (120) @(posedge clk);
	endtask

	task automatic set_master(logic [15:0] gl, logic [15:0] gr);
		cfg_we    <= 1'b1;
		cfg_index <= R_GAIN_L;
		cfg_data  <= gl;
		@(posedge clk);
		cfg_index <= R_GAIN_R;
		cfg_data  <= gr;
		@(posedge clk);
		cfg_we <= 1'b0;
		master_l = gl > GAIN_ONE ? GAIN_ONE : gl;
		master_r = gr > GAIN_ONE ? GAIN_ONE : gr;
	endtask

	// Response side: random stalls, one long hold-off, checks
	initial begin
		int hold;
		mix_rsp_t e;
		hold = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && n_sent > FILL_WORDS + 40) begin
				long_hold_done = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else if (calm || $urandom_range(0, 99) < 70) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b0;
				hold = $urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 3);
			end
			@(negedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_got++;
				if (mix_pending.size() == 0) begin
					$error("response with nothing expected");
					n_errors++;
				end else begin
					e = mix_pending.pop_front();
					if (rsp_ch.out_left !== e.out_left) begin
						$error("out_left: expected %0d, got %0d", e.out_left, rsp_ch.out_left);
						n_errors++;
					end
					if (rsp_ch.out_right !== e.out_right) begin
						$error("out_right: expected %0d, got %0d", e.out_right, rsp_ch.out_right);
						n_errors++;
					end
					if (rsp_ch.granted_slot !== e.granted_slot) begin
						$error("granted_slot: expected %0d, got %0d", e.granted_slot,
							rsp_ch.granted_slot);
						n_errors++;
					end
					if (rsp_ch.no_free_slot !== e.no_free_slot) begin
						$error("no_free_slot: expected %0d, got %0d", e.no_free_slot,
							rsp_ch.no_free_slot);
						n_errors++;
					end
				end
			end
		end
	end

	// Stimulus
	initial begin
		dir_row_t rows [$];
		mix_req_t r;
		mix_rsp_t none;
		logic [15:0] gains [5][2];
		n_errors = 0;
		n_sent = 0;
		n_got = 0;
		n_frames = 0;
		n_nofree = 0;
		n_sat = 0;
		calm = 1'b0;
		long_hold_done = 1'b0;
		none = '{16'sd0, 16'sd0, 4'd0, 1'b0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = R_GAIN_L;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = K_LOAD;
		req_ch.address = '0;
		req_ch.length = '0;
		req_ch.left_sample = '0;
		req_ch.right_sample = '0;
		req_ch.gain_left = '0;
		req_ch.gain_right = '0;
		req_ch.looped = 1'b0;
		req_ch.slot = '0;
		req_ch.end_of_buffer = 1'b0;
		for (int v = 0; v < VOICES; v++) begin
			v_act[v] = 1'b0;
			v_loop[v] = 1'b0;
		end
		master_l = GAIN_ONE;
		master_r = GAIN_ONE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Silence straight after reset, then fill the low part of the store
		send_req('{K_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1}, 1'b1, none);
		for (int a = 0; a < FILL_WORDS; a++) begin
			r = rand_req();
			r.kind = K_LOAD;
			r.address = a[13:0];
			send_req(r, 1'b0, none);
		end

		// Directed: extremes, wrap of the store address, zero length, saturation
		rows.push_back(mk_row(K_STOP, 0, 0, 0, 0, 0, 0, 0, 15, 0, 1, 0));
		rows.push_back(mk_row(K_LOAD, 16383, 0, -32768, 32767, 0, 0, 0, 0, 0, 1, 0));
		rows.push_back(mk_row(K_LOAD, 0, 0, 32767, -32768, 0, 0, 0, 0, 0, 1, 0));
		rows.push_back(mk_row(K_LOAD, 1, 0, 'h5555, 'hAAAA, 0, 0, 0, 0, 0, 1, 0));
		rows.push_back(mk_row(K_PLAY, 16383, 2, 0, 0, 65535, 65535, 1, 0, 0, 1, 0));
		rows.push_back(mk_row(K_PLAY, 0, 0, 0, 0, 0, 65535, 0, 0, 0, 1, 1));
		rows.push_back(mk_row(K_PLAY, 16383, 3, 0, 0, 32768, 32768, 0, 0, 0, 1, 2));
		rows.push_back(mk_row(K_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(K_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
		rows.push_back(mk_row(K_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(K_STOP, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0));
		rows.push_back(mk_row(K_PLAY, 1, 16384, 0, 0, 1, 1, 1, 0, 0, 1, 1));
		rows.push_back(mk_row(K_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
		// fill every slot, then one play too many
		for (int i = 0; i < 15; i++)
			rows.push_back(mk_row(K_PLAY, 16383, 1, 0, 0, 65535, 65535, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(K_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
		// the long voice would run past the loaded words
		rows.push_back(mk_row(K_STOP, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0));
		foreach (rows[i])
			send_req(rows[i].r, rows[i].typed, rows[i].e);

		// Random phases under different master gains
		gains = '{'{16'd32768, 16'd32768}, '{16'd0, 16'd65535}, '{16'd65535, 16'd0},
			'{16'd16384, 16'd40000}, '{16'd1, 16'd32767}};
		for (int ph = 0; ph < 6; ph++) begin
			req_ch.valid <= 1'b0;
			drain();
			if (ph < 5)
				set_master(gains[ph][0], gains[ph][1]);
			else
				set_master(16'($urandom), 16'($urandom));
			calm = ph == 2;
			for (int i = 0; i < 150; i++)
				send_req(rand_req(), 1'b0, none);
		end
		req_ch.valid <= 1'b0;
		drain();

		$display("Sent %0d requests, %0d responses, %0d frames mixed.", n_sent, n_got,
			n_frames);
		$display("Plays refused for lack of a slot: %0d, saturated channel sums: %0d.",
			n_nofree, n_sat);
		if (n_errors == 0 && mix_pending.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
